/* hw/rtl/rrts_pkg.sv */
package rrts_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int ID_W    = 8;
    localparam int REM_W   = 16;
    localparam int TIME_W  = 32;
    localparam int ENTRY_W = ID_W + REM_W;

    // request codes
    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;    // latch the incoming word
        logic push_held;  // move a held entry into the queue tail
        logic arr_step;   // finish an arrival and load the result
        logic tick_step;  // serve the head slot and load the result
    } t_cmd;

endpackage

/* hw/rtl/round_robin_tick_scheduler.sv */
// channel | direction | handshake               | word
// --------+-----------+-------------------------+------------------------------------------
// in      | input     | i_in_valid / o_in_stall | i_req_type, i_proc_id, i_burst_time
// out     | output    | o_out_valid / i_out_stall | o_accepted, o_rejected, o_ran_valid,
//         |           |                         | o_ran_id, o_finished, o_slot_time
//
// an arrival passes through S_ARR, a tick through S_PUSH, S_READ and S_SERVE, before the next acceptance
// a tick costs more because the held entry is written into the queue ram (one write port)
// before the head is read, and the ram read is registered
// one word is in work at a time; a result waiting on i_out_stall holds the block
// reset (synchronous, active low) empties the queue and clears the held entry and time
module round_robin_tick_scheduler (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic [rrts_pkg::ID_W-1:0]    i_proc_id,
    input  logic [rrts_pkg::REM_W-1:0]   i_burst_time,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_accepted,
    output logic                         o_rejected,
    output logic                         o_ran_valid,
    output logic [rrts_pkg::ID_W-1:0]    o_ran_id,
    output logic                         o_finished,
    output logic [rrts_pkg::TIME_W-1:0]  o_slot_time
);
    import rrts_pkg::*;

    t_cmd cmd;
    logic out_free;

    // sequencer
    rrts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_out_free (out_free),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // queue, held entry, time and result register
    rrts_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_proc_id    (i_proc_id),
        .i_burst_time (i_burst_time),
        .i_out_stall  (i_out_stall),
        .o_out_free   (out_free),
        .o_out_valid  (o_out_valid),
        .o_accepted   (o_accepted),
        .o_rejected   (o_rejected),
        .o_ran_valid  (o_ran_valid),
        .o_ran_id     (o_ran_id),
        .o_finished   (o_finished),
        .o_slot_time  (o_slot_time)
    );

endmodule

/* hw/rtl/rrts_ram.sv */
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* hw/rtl/rrts_ctrl.sv */
module rrts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_req_type,
    input  logic          i_out_free,
    output logic          o_in_stall,
    output rrts_pkg::t_cmd o_cmd
);
    import rrts_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ARR   = 3'd1;
    localparam logic [2:0] S_PUSH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_SERVE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_req_type == REQ_TICK) ? S_PUSH : S_ARR;
                end
            end
            S_ARR: begin
                if (i_out_free) begin
                    o_cmd.arr_step = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PUSH: begin
                o_cmd.push_held = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_SERVE;
            end
            S_SERVE: begin
                if (i_out_free) begin
                    o_cmd.tick_step = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/rrts_dp.sv */
module rrts_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rrts_pkg::t_cmd               i_cmd,
    input  logic [rrts_pkg::ID_W-1:0]    i_proc_id,
    input  logic [rrts_pkg::REM_W-1:0]   i_burst_time,
    input  logic                         i_out_stall,
    output logic                         o_out_free,
    output logic                         o_out_valid,
    output logic                         o_accepted,
    output logic                         o_rejected,
    output logic                         o_ran_valid,
    output logic [rrts_pkg::ID_W-1:0]    o_ran_id,
    output logic                         o_finished,
    output logic [rrts_pkg::TIME_W-1:0]  o_slot_time
);
    import rrts_pkg::*;

    // captured word
    logic [ID_W-1:0]  r_id;
    logic [REM_W-1:0] r_burst;

    // queue and scheduler state
    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_tail;
    logic [CNT_W-1:0]  r_count;
    logic              r_held_valid;
    logic [ID_W-1:0]   r_held_id;
    logic [REM_W-1:0]  r_held_rem;
    logic [TIME_W-1:0] r_time;

    logic               we;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;
    logic [CNT_W:0]     used;
    logic               arr_ok;
    logic               do_push;
    logic               do_pop;
    logic               has_head;
    logic [REM_W-1:0]   rem_dec;
    logic               rem_zero;
    logic [PTR_W-1:0]   tail_nxt;
    logic [PTR_W-1:0]   head_nxt;

    // pointer wrap
    assign tail_nxt = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
    assign head_nxt = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);

    // arrival admission
    assign used   = {1'b0, r_count} + {{CNT_W{1'b0}}, r_held_valid};
    assign arr_ok = (r_burst != '0) && (used < (CNT_W + 1)'(QUEUE_DEPTH));

    // head service
    assign has_head = (r_count != '0);
    assign rem_dec  = rdata[REM_W-1:0] - REM_W'(1);
    assign rem_zero = (rem_dec == '0);

    assign do_push = (i_cmd.push_held && r_held_valid) || (i_cmd.arr_step && arr_ok);
    assign do_pop  = i_cmd.tick_step && has_head;

    assign we    = do_push;
    assign wdata = i_cmd.push_held ? {r_held_id, r_held_rem} : {r_id, r_burst};

    rrts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_tail),
        .i_wdata (wdata),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    assign o_out_free = !o_out_valid || !i_out_stall;

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_id    <= i_proc_id;
            r_burst <= i_burst_time;
        end
    end

    // queue pointers, count, held entry and time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_held_valid <= 1'b0;
            r_held_id    <= '0;
            r_held_rem   <= '0;
            r_time       <= '0;
        end else begin
            if (do_push) begin
                r_tail  <= tail_nxt;
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.push_held) begin
                r_held_valid <= 1'b0;
            end
            if (do_pop) begin
                r_head  <= head_nxt;
                r_count <= r_count - CNT_W'(1);
                if (!rem_zero) begin
                    r_held_valid <= 1'b1;
                    r_held_id    <= rdata[ENTRY_W-1:REM_W];
                    r_held_rem   <= rem_dec;
                end
            end
            if (i_cmd.tick_step) begin
                r_time <= r_time + TIME_W'(1);
            end
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.arr_step || i_cmd.tick_step) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.arr_step || i_cmd.tick_step) begin
            o_accepted  <= i_cmd.arr_step && arr_ok;
            o_rejected  <= i_cmd.arr_step && !arr_ok;
            o_ran_valid <= do_pop;
            o_ran_id    <= do_pop ? rdata[ENTRY_W-1:REM_W] : '0;
            o_finished  <= do_pop && rem_zero;
            o_slot_time <= r_time;
        end
    end

endmodule

/* sim/round_robin_tick_scheduler_test.sv */
`timescale 1ns / 100ps

module round_robin_tick_scheduler_test;

    import rrts_pkg::*;

    // one result word as the block reports it
    typedef struct packed {
        logic              accepted;
        logic              rejected;
        logic              ran_valid;
        logic [ID_W-1:0]   ran_id;
        logic              finished;
        logic [TIME_W-1:0] slot_time;
    } t_slot_result;

    // one input word, with an optional hand-typed result
    typedef struct {
        logic             req;
        logic [ID_W-1:0]  id;
        logic [REM_W-1:0] burst;
        bit               typed;
        t_slot_result     want;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_stall;
    logic              i_req_type   = REQ_ARRIVAL;
    logic [ID_W-1:0]   i_proc_id    = '0;
    logic [REM_W-1:0]  i_burst_time = '0;
    logic              o_out_valid;
    logic              i_out_stall  = 1'b0;
    logic              o_accepted;
    logic              o_rejected;
    logic              o_ran_valid;
    logic [ID_W-1:0]   o_ran_id;
    logic              o_finished;
    logic [TIME_W-1:0] o_slot_time;

    // scheduler state as the testbench tracks it
    logic [ID_W-1:0]   ready_id   [QUEUE_DEPTH];
    logic [REM_W-1:0]  ready_left [QUEUE_DEPTH];
    int                ready_head  = 0;
    int                ready_tail  = 0;
    int                ready_count = 0;
    bit                held_valid  = 1'b0;
    logic [ID_W-1:0]   held_id     = '0;
    logic [REM_W-1:0]  held_left   = '0;
    logic [TIME_W-1:0] sched_now   = '0;

    t_slot_result      pending_slots [$];
    t_stim_row         directed_rows [$];
    int                send_idle_pct = 6;
    int                recv_stall_pct = 60;
    int                fail_count = 0;
    int                n_words = 0, n_queued = 0, n_refused = 0;
    int                n_ran = 0, n_done = 0, n_idle = 0;

    round_robin_tick_scheduler u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_proc_id    (i_proc_id),
        .i_burst_time (i_burst_time),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_accepted   (o_accepted),
        .o_rejected   (o_rejected),
        .o_ran_valid  (o_ran_valid),
        .o_ran_id     (o_ran_id),
        .o_finished   (o_finished),
        .o_slot_time  (o_slot_time)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // ready fifo append
    function automatic void push_ready(logic [ID_W-1:0] id, logic [REM_W-1:0] left);
        ready_id[ready_tail]   = id;
        ready_left[ready_tail] = left;
        ready_tail  = (ready_tail + 1) % QUEUE_DEPTH;
        ready_count++;
    endfunction

    // advance the scheduler by one word and return its slot result
    function automatic t_slot_result schedule_step(logic req, logic [ID_W-1:0] id,
                                                   logic [REM_W-1:0] burst);
        t_slot_result     r;
        logic [REM_W-1:0] left;
        r = '0;
        r.slot_time = sched_now;
        n_words++;
        if (req == REQ_ARRIVAL) begin
            if (burst == '0 || ready_count + int'(held_valid) >= QUEUE_DEPTH) begin
                r.rejected = 1'b1;
                n_refused++;
            end else begin
                push_ready(id, burst);
                r.accepted = 1'b1;
                n_queued++;
            end
        end else begin
            // preempted process goes back in behind this tick's arrivals
            if (held_valid) begin
                push_ready(held_id, held_left);
                held_valid = 1'b0;
            end
            if (ready_count > 0) begin
                left        = ready_left[ready_head] - 1'b1;
                r.ran_valid = 1'b1;
                r.ran_id    = ready_id[ready_head];
                ready_head  = (ready_head + 1) % QUEUE_DEPTH;
                ready_count--;
                n_ran++;
                if (left == '0) begin
                    r.finished = 1'b1;
                    n_done++;
                end else begin
                    held_valid = 1'b1;
                    held_id    = r.ran_id;
                    held_left  = left;
                end
            end else begin
                n_idle++;
            end
            sched_now++;
        end
        return r;
    endfunction

    function automatic t_slot_result mk_result(logic acc, logic rej, logic ran,
                                               logic [ID_W-1:0] id, logic fin,
                                               logic [TIME_W-1:0] t);
        t_slot_result r;
        r = '{accepted: acc, rejected: rej, ran_valid: ran, ran_id: id,
              finished: fin, slot_time: t};
        return r;
    endfunction

    function automatic void add_row(logic req, logic [ID_W-1:0] id, logic [REM_W-1:0] burst,
                                    bit typed, t_slot_result want);
        t_stim_row row;
        row.req   = req;
        row.id    = id;
        row.burst = burst;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // present one word, wait for it to be taken, then record its expected slot
    task automatic send_word(input t_stim_row row);
        int           gap;
        t_slot_result predicted;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= row.req;
        i_proc_id    <= row.id;
        i_burst_time <= row.burst;
        do @(posedge i_clk); while (o_in_stall);
        predicted = schedule_step(row.req, row.id, row.burst);
        pending_slots.push_back(row.typed ? row.want : predicted);
    endtask

    // hold the sender off until every slot result is back
    task automatic drain_slots();
        i_in_valid <= 1'b0;
        while (pending_slots.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // random word mix: arrival-heavy and tick-heavy stretches, mostly short bursts
    task automatic run_random(input int count);
        t_stim_row row;
        int        arrival_pct;
        int        pick;
        arrival_pct = 50;
        row.typed   = 1'b0;
        row.want    = '0;
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(2))
                    0: arrival_pct = 25;
                    1: arrival_pct = 50;
                    default: arrival_pct = 75;
                endcase
            end
            row.req = ($urandom_range(99) < arrival_pct) ? REQ_ARRIVAL : REQ_TICK;
            row.id  = ID_W'($urandom_range(255));
            pick    = $urandom_range(99);
            if (row.req == REQ_TICK)
                row.burst = REM_W'($urandom_range(65535));
            else if (pick < 70)
                row.burst = REM_W'($urandom_range(4, 1));
            else if (pick < 79)
                row.burst = '0;
            else if (pick < 99)
                row.burst = REM_W'($urandom_range(40, 5));
            else
                row.burst = REM_W'($urandom_range(65535));
            send_word(row);
        end
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_slot_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_slots.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                want = pending_slots.pop_front();
                if (o_accepted !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, o_accepted);
                    fail_count++;
                end
                if (o_rejected !== want.rejected) begin
                    $error("rejected: expected %0d, got %0d", want.rejected, o_rejected);
                    fail_count++;
                end
                if (o_ran_valid !== want.ran_valid) begin
                    $error("ran_valid: expected %0d, got %0d", want.ran_valid, o_ran_valid);
                    fail_count++;
                end
                if (o_ran_id !== want.ran_id) begin
                    $error("ran_id: expected %0d, got %0d", want.ran_id, o_ran_id);
                    fail_count++;
                end
                if (o_finished !== want.finished) begin
                    $error("finished: expected %0d, got %0d", want.finished, o_finished);
                    fail_count++;
                end
                if (o_slot_time !== want.slot_time) begin
                    $error("slot_time: expected %0d, got %0d", want.slot_time, o_slot_time);
                    fail_count++;
                end
            end
        end
    end

    // main sequence
    initial begin
        // directed words: idle slot, zero burst, extremes, preemption order, full queue
        add_row(REQ_TICK,    8'd0,   16'd0,     1'b1,
                mk_result(1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 32'd0));
        add_row(REQ_ARRIVAL, 8'd7,   16'd0,     1'b1,
                mk_result(1'b0, 1'b1, 1'b0, 8'd0, 1'b0, 32'd1));
        add_row(REQ_ARRIVAL, 8'd255, 16'hFFFF,  1'b1,
                mk_result(1'b1, 1'b0, 1'b0, 8'd0, 1'b0, 32'd1));
        add_row(REQ_ARRIVAL, 8'd0,   16'd1,     1'b0, '0);
        add_row(REQ_TICK,    8'hFF,  16'hFFFF,  1'b0, '0);
        add_row(REQ_ARRIVAL, 8'hAA,  16'd1,     1'b0, '0);
        add_row(REQ_TICK,    8'h55,  16'h5555,  1'b0, '0);
        add_row(REQ_TICK,    8'hAA,  16'hAAAA,  1'b0, '0);
        // fill to the brim, then one refused arrival
        for (int n = 1; n <= QUEUE_DEPTH - 1; n++)
            add_row(REQ_ARRIVAL, ID_W'(n), REM_W'(n % 3 + 1), 1'b0, '0);
        add_row(REQ_ARRIVAL, 8'd200, 16'd3, 1'b1,
                mk_result(1'b0, 1'b1, 1'b0, 8'd0, 1'b0, 32'd4));
        // a held entry counts as occupancy
        add_row(REQ_TICK,    8'd0,   16'd0, 1'b0, '0);
        add_row(REQ_ARRIVAL, 8'd201, 16'd2, 1'b1,
                mk_result(1'b0, 1'b1, 1'b0, 8'd0, 1'b0, 32'd5));
        add_row(REQ_TICK,    8'd0,   16'd0, 1'b0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) send_word(directed_rows[r]);

        // sender rarely idle, receiver mostly stalled
        run_random(540);
        drain_slots();

        // sender mostly idle, receiver rarely stalled
        send_idle_pct  = 60;
        recv_stall_pct = 6;
        run_random(540);
        drain_slots();

        // full rate both ways
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(545);
        drain_slots();
        repeat (10) @(posedge i_clk);

        $display("run covered %0d words: %0d arrivals queued, %0d refused",
                 n_words, n_queued, n_refused);
        $display("slots: %0d ran, %0d finished, %0d idle; final time %0d",
                 n_ran, n_done, n_idle, sched_now);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
